@@ rtl/acd_pkg.sv @@
package acd_pkg;

  // Default widths and depths handed to the top level parameters.
  localparam int POSITION_BITS_DEF = 48;
  localparam int LEVEL_BITS_DEF    = 16;
  localparam int QUEUE_DEPTH_DEF   = 2;

  // Fixed widths of the configuration registers and port.
  localparam int TOL_BITS       = 16;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 1;

  // Register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_THIN_TOLERANCE = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BOOL_MODE      = 1'd1;

  // Input word kinds.
  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_STOP   = 2'd2;

  // Capture modes that change behavior; latch and trim act as write without an anchor.
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_TOUCH = 2'd1;

  // Control part of one queue entry: how many points it carries and their shape.
  typedef struct packed {
    logic two_points;
    logic step;
  } pair_ctl_t;

endpackage

@@ rtl/acd_front.sv @@
module acd_front
  import acd_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int LEVEL_BITS    = LEVEL_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_fire,
  input  logic [1:0]                kind,
  input  logic [POSITION_BITS-1:0]  position,
  input  logic [LEVEL_BITS-1:0]     level,
  input  logic                      touch_mark,
  input  logic [1:0]                capture_mode,
  output logic                      push,
  output pair_ctl_t                 push_ctl,
  output logic [POSITION_BITS-1:0]  push_pos0,
  output logic [LEVEL_BITS-1:0]     push_lvl0,
  output logic [POSITION_BITS-1:0]  push_pos1,
  output logic [LEVEL_BITS-1:0]     push_lvl1
);

  localparam int CMP_BITS = (LEVEL_BITS > TOL_BITS) ? LEVEL_BITS : TOL_BITS;

  // Boolean quantization: strictly above one half is exactly the top bit set.
  function automatic logic [LEVEL_BITS-1:0] quant(input logic [LEVEL_BITS-1:0] v,
                                                  input logic b);
    quant = b ? {LEVEL_BITS{v[LEVEL_BITS-1]}} : v;
  endfunction

  logic [TOL_BITS-1:0]      thin_tolerance;
  logic                     bool_mode;

  logic                     recording, recording_next;
  logic [1:0]               mode_now, mode_now_next;
  logic [POSITION_BITS-1:0] start_position, start_position_next;
  logic                     have_points, have_points_next;
  logic [POSITION_BITS-1:0] held_position, held_position_next;
  logic [LEVEL_BITS-1:0]    held_level, held_level_next;
  logic [LEVEL_BITS-1:0]    pretouch_level, pretouch_level_next;
  logic                     held_pending, held_pending_next;
  logic [POSITION_BITS-1:0] emitted_position, emitted_position_next;

  logic [LEVEL_BITS-1:0]    q;
  logic [LEVEL_BITS-1:0]    diff;
  logic                     anchor;
  logic                     thin;
  logic                     close_pt;
  logic [POSITION_BITS-1:0] last_emit_pos;
  logic [LEVEL_BITS-1:0]    close_level;
  logic [1:0]               n_emit;

  assign q    = quant(level, bool_mode);
  assign diff = (q > held_level) ? (q - held_level) : (held_level - q);

  always_comb begin
    recording_next        = recording;
    mode_now_next         = mode_now;
    start_position_next   = start_position;
    have_points_next      = have_points;
    held_position_next    = held_position;
    held_level_next       = held_level;
    pretouch_level_next   = pretouch_level;
    held_pending_next     = held_pending;
    emitted_position_next = emitted_position;
    n_emit                = 2'd0;
    push_pos0             = position;
    push_lvl0             = q;
    push_pos1             = position;
    push_lvl1             = q;
    anchor                = 1'b0;
    thin                  = 1'b0;
    close_pt              = 1'b0;
    last_emit_pos         = emitted_position;
    close_level           = quant(held_level, bool_mode);

    case (kind)
      KIND_START: begin
        recording_next        = 1'b1;
        mode_now_next         = capture_mode;
        start_position_next   = position;
        have_points_next      = 1'b0;
        held_position_next    = '0;
        held_level_next       = level;
        pretouch_level_next   = level;
        held_pending_next     = 1'b0;
        emitted_position_next = '0;
      end
      KIND_SAMPLE: begin
        if (recording) begin
          if (!have_points || touch_mark) begin
            pretouch_level_next = q;
          end
          anchor = !have_points && (mode_now == MODE_WRITE) && (start_position < position);
          // The first point of a write run thins against the initial level when it makes an anchor.
          thin = (have_points || anchor) &&
                 (CMP_BITS'(diff) < CMP_BITS'(thin_tolerance));
          held_position_next = position;
          held_level_next    = q;
          held_pending_next  = thin;
          have_points_next   = 1'b1;
          if (anchor) begin
            push_pos0 = start_position;
            push_lvl0 = q;
          end else if (held_pending) begin
            push_pos0 = held_position;
            push_lvl0 = held_level;
          end
          if (thin) begin
            n_emit = anchor ? 2'd1 : 2'd0;
            if (anchor) begin
              emitted_position_next = start_position;
            end
          end else begin
            n_emit = (anchor || held_pending) ? 2'd2 : 2'd1;
            emitted_position_next = position;
          end
        end
      end
      KIND_STOP: begin
        if (recording) begin
          if (have_points) begin
            last_emit_pos = held_pending ? held_position : emitted_position;
            if (mode_now == MODE_TOUCH) begin
              close_pt    = 1'b1;
              close_level = quant(pretouch_level, bool_mode);
            end else begin
              close_pt = last_emit_pos < position;
            end
            if (held_pending) begin
              push_pos0 = held_position;
              push_lvl0 = held_level;
              push_pos1 = position;
              push_lvl1 = close_level;
              n_emit    = close_pt ? 2'd2 : 2'd1;
            end else begin
              push_pos0 = position;
              push_lvl0 = close_level;
              n_emit    = close_pt ? 2'd1 : 2'd0;
            end
          end
          recording_next    = 1'b0;
          held_pending_next = 1'b0;
          have_points_next  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign push                = in_fire && (n_emit != 2'd0);
  assign push_ctl.two_points = (n_emit == 2'd2);
  assign push_ctl.step       = bool_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      thin_tolerance   <= '0;
      bool_mode        <= 1'b0;
      recording        <= 1'b0;
      mode_now         <= MODE_WRITE;
      start_position   <= '0;
      have_points      <= 1'b0;
      held_position    <= '0;
      held_level       <= '0;
      pretouch_level   <= '0;
      held_pending     <= 1'b0;
      emitted_position <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_THIN_TOLERANCE: thin_tolerance <= cfg_data[TOL_BITS-1:0];
          REG_BOOL_MODE:      bool_mode      <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        recording        <= recording_next;
        mode_now         <= mode_now_next;
        start_position   <= start_position_next;
        have_points      <= have_points_next;
        held_position    <= held_position_next;
        held_level       <= held_level_next;
        pretouch_level   <= pretouch_level_next;
        held_pending     <= held_pending_next;
        emitted_position <= emitted_position_next;
      end
    end
  end

endmodule

@@ rtl/acd_queue.sv @@
module acd_queue
  import acd_pkg::*;
#(
  parameter int DEPTH     = QUEUE_DEPTH_DEF,
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output logic [DATA_BITS-1:0] pop_data
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [DATA_BITS-1:0] slots [DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr;
  logic [PTR_BITS-1:0]  rd_ptr;
  logic [CNT_BITS-1:0]  count;

  assign full      = (count == CNT_BITS'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_data;
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/acd_back.sv @@
module acd_back
  import acd_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int LEVEL_BITS    = LEVEL_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  input  pair_ctl_t                q_ctl,
  input  logic [POSITION_BITS-1:0] q_pos0,
  input  logic [LEVEL_BITS-1:0]    q_lvl0,
  input  logic [POSITION_BITS-1:0] q_pos1,
  input  logic [LEVEL_BITS-1:0]    q_lvl1,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [POSITION_BITS-1:0] point_position,
  output logic [LEVEL_BITS-1:0]    point_level,
  output logic                     step_shape,
  output logic                     last_of_run
);

  logic                     second_pending;
  logic [POSITION_BITS-1:0] second_pos;
  logic [LEVEL_BITS-1:0]    second_lvl;
  logic                     second_step;
  logic                     load;

  // The output register takes a new word when it is empty or being drained.
  assign load = !out_valid || out_ready;
  assign pop  = load && !second_pending && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      second_pending <= 1'b0;
    end else if (load) begin
      if (second_pending) begin
        out_valid      <= 1'b1;
        point_position <= second_pos;
        point_level    <= second_lvl;
        step_shape     <= second_step;
        last_of_run    <= 1'b1;
        second_pending <= 1'b0;
      end else if (q_valid) begin
        out_valid      <= 1'b1;
        point_position <= q_pos0;
        point_level    <= q_lvl0;
        step_shape     <= q_ctl.step;
        last_of_run    <= !q_ctl.two_points;
        second_pending <= q_ctl.two_points;
        second_pos     <= q_pos1;
        second_lvl     <= q_lvl1;
        second_step    <= q_ctl.step;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/automation_capture_deadband.sv @@
// Path: the first point of an input word goes through the entry queue into the output
// register; when the word makes two points, the second follows once the first is taken.
// Throughput: one input word per cycle while words make at most one point and the queue
// has room; the output moves one point per cycle while out_ready is high, so a long
// train of two-point words fills the two-entry queue and then holds the input back.
// Reset (synchronous, active high) clears the run state, both configuration registers,
// the entry queue and the output register's valid.
module automation_capture_deadband
  import acd_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int LEVEL_BITS    = LEVEL_BITS_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                kind,
  input  logic [POSITION_BITS-1:0]  position,
  input  logic [LEVEL_BITS-1:0]     level,
  input  logic                      touch_mark,
  input  logic [1:0]                capture_mode,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [POSITION_BITS-1:0]  point_position,
  output logic [LEVEL_BITS-1:0]     point_level,
  output logic                      step_shape,
  output logic                      last_of_run
);

  // One queue entry carries the control bits and up to two points made by one word.
  localparam int ENTRY_BITS = $bits(pair_ctl_t) + 2 * (POSITION_BITS + LEVEL_BITS);

  logic                     in_fire;
  logic                     push;
  pair_ctl_t                push_ctl;
  logic [POSITION_BITS-1:0] push_pos0;
  logic [LEVEL_BITS-1:0]    push_lvl0;
  logic [POSITION_BITS-1:0] push_pos1;
  logic [LEVEL_BITS-1:0]    push_lvl1;
  logic                     q_full;
  logic                     q_valid;
  logic                     pop;
  logic [ENTRY_BITS-1:0]    q_data;
  pair_ctl_t                q_ctl;
  logic [POSITION_BITS-1:0] q_pos0;
  logic [LEVEL_BITS-1:0]    q_lvl0;
  logic [POSITION_BITS-1:0] q_pos1;
  logic [LEVEL_BITS-1:0]    q_lvl1;

  // The front side takes a word whenever the queue has room, regardless of whether
  // the output side is stalled. A word that makes no point still needs the room check
  // only to keep the rule simple; it never writes the queue.
  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;

  // The front part holds the run state and the configuration registers, classifies
  // each word and works out, in the cycle it is accepted, which points it makes.
  acd_front #(
    .POSITION_BITS (POSITION_BITS),
    .LEVEL_BITS    (LEVEL_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_fire      (in_fire),
    .kind         (kind),
    .position     (position),
    .level        (level),
    .touch_mark   (touch_mark),
    .capture_mode (capture_mode),
    .push         (push),
    .push_ctl     (push_ctl),
    .push_pos0    (push_pos0),
    .push_lvl0    (push_lvl0),
    .push_pos1    (push_pos1),
    .push_lvl1    (push_lvl1)
  );

  // A short queue of point pairs decouples the front from the output handshake.
  acd_queue #(
    .DEPTH     (QUEUE_DEPTH),
    .DATA_BITS (ENTRY_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_ctl, push_pos0, push_lvl0, push_pos1, push_lvl1}),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  assign {q_ctl, q_pos0, q_lvl0, q_pos1, q_lvl1} = q_data;

  // The back part splits each pair into single output words and marks the last one.
  acd_back #(
    .POSITION_BITS (POSITION_BITS),
    .LEVEL_BITS    (LEVEL_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_ctl          (q_ctl),
    .q_pos0         (q_pos0),
    .q_lvl0         (q_lvl0),
    .q_pos1         (q_pos1),
    .q_lvl1         (q_lvl1),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .point_position (point_position),
    .point_level    (point_level),
    .step_shape     (step_shape),
    .last_of_run    (last_of_run)
  );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

// Breakpoint capture with deadband thinning: the test streams start, sample
// and stop words into the block. A scoreboard keeps its own copy of the run
// state and predicts the points each word should produce. Every point that
// leaves the block is checked against the oldest prediction.
module tb;
  import acd_pkg::*;

  localparam int PW = POSITION_BITS_DEF;
  localparam int LW = LEVEL_BITS_DEF;
  localparam int FULL = (1 << LW) - 1;
  localparam logic [LW-1:0] FULL_SCALE = '1;
  // Kind three has no meaning and the block must drop it silently.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [1:0] MODE_LATCH = 2'd2;
  localparam logic [1:0] MODE_TRIM = 2'd3;
  localparam int CYCLE_LIMIT = 500000;
  localparam int WORDS_PER_PHASE = 125;

  typedef struct packed {
    logic [PW-1:0] pos;
    logic [LW-1:0] lvl;
    logic          step;
    logic          last;
  } point_t;

  // The scoreboard holds the predicted points in arrival order, together
  // with the run state and the configuration that produce them.
  class capture_board;
    int errors;
    point_t expected_points[$];
    logic [TOL_BITS-1:0] tolerance;
    logic boolean_mode;
    logic run_active;
    logic [1:0] run_mode;
    logic [PW-1:0] run_start;
    logic has_points;
    logic [PW-1:0] hold_pos;
    logic [LW-1:0] hold_lvl;
    logic [LW-1:0] pre_touch_lvl;
    logic hold_valid;
    logic [PW-1:0] last_out_pos;

    function new();
      errors = 0;
      tolerance = '0;
      boolean_mode = 1'b0;
      run_active = 1'b0;
      run_mode = MODE_WRITE;
      run_start = '0;
      has_points = 1'b0;
      hold_pos = '0;
      hold_lvl = '0;
      pre_touch_lvl = '0;
      hold_valid = 1'b0;
      last_out_pos = '0;
    endfunction

    function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      if (idx == REG_THIN_TOLERANCE) begin
        tolerance = data[TOL_BITS-1:0];
      end else if (idx == REG_BOOL_MODE) begin
        boolean_mode = data[0];
      end
    endfunction

    function int pending();
      return expected_points.size();
    endfunction

    // Boolean parameters snap to full scale strictly above one half.
    function logic [LW-1:0] quantized(logic [LW-1:0] v);
      if (!boolean_mode) return v;
      return (2 * int'(v) > FULL) ? FULL_SCALE : '0;
    endfunction

    function void add_point(logic [PW-1:0] p, logic [LW-1:0] l);
      point_t pt;
      pt.pos = p;
      pt.lvl = l;
      pt.step = boolean_mode;
      pt.last = 1'b0;
      expected_points.insert(expected_points.size(), pt);
      last_out_pos = p;
      has_points = 1'b1;
    endfunction

    function void note_word(logic [1:0] k, logic [PW-1:0] p, logic [LW-1:0] l,
                            logic t, logic [1:0] m);
      logic [LW-1:0] q;
      logic [LW-1:0] gap;
      int first_new;
      first_new = expected_points.size();
      if (k == KIND_START) begin
        // A start drops whatever run was open and arms a fresh one.
        run_active = 1'b1;
        run_mode = m;
        run_start = p;
        has_points = 1'b0;
        hold_pos = '0;
        hold_lvl = l;
        pre_touch_lvl = l;
        hold_valid = 1'b0;
        last_out_pos = '0;
        return;
      end
      if (!run_active) return;
      if (k == KIND_SAMPLE) begin
        q = quantized(l);
        if (!has_points || t) begin
          pre_touch_lvl = q;
          if (!has_points && run_mode == MODE_WRITE && run_start < p) add_point(run_start, q);
        end
        gap = (q > hold_lvl) ? q - hold_lvl : hold_lvl - q;
        if (has_points && gap < tolerance) begin
          hold_valid = 1'b1;
          hold_pos = p;
          hold_lvl = q;
        end else begin
          if (hold_valid) add_point(hold_pos, hold_lvl);
          add_point(p, q);
          hold_pos = p;
          hold_lvl = q;
          hold_valid = 1'b0;
        end
      end else if (k == KIND_STOP) begin
        if (has_points) begin
          if (hold_valid) add_point(hold_pos, hold_lvl);
          if (run_mode == MODE_TOUCH) begin
            add_point(p, quantized(pre_touch_lvl));
          end else if (last_out_pos < p) begin
            add_point(p, quantized(hold_lvl));
          end
        end
        run_active = 1'b0;
        hold_valid = 1'b0;
        has_points = 1'b0;
      end
      if (expected_points.size() > first_new) begin
        expected_points[expected_points.size() - 1].last = 1'b1;
      end
    endfunction

    function void check_point(logic [PW-1:0] p, logic [LW-1:0] l, logic s, logic z);
      point_t want;
      if (expected_points.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected point: pos %h lvl %h step %b last %b", p, l, s, z);
        end
        return;
      end
      want = expected_points.pop_front();
      if (want.pos !== p || want.lvl !== l || want.step !== s || want.last !== z) begin
        errors++;
        if (errors <= 10) begin
          $display("point mismatch: expected pos %h lvl %h step %b last %b,",
                   want.pos, want.lvl, want.step, want.last,
                   " got pos %h lvl %h step %b last %b", p, l, s, z);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = KIND_START;
  logic [PW-1:0] position = '0;
  logic [LW-1:0] level = '0;
  logic touch_mark = 1'b0;
  logic [1:0] capture_mode = MODE_WRITE;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PW-1:0] point_position;
  logic [LW-1:0] point_level;
  logic step_shape;
  logic last_of_run;

  capture_board board;
  // Percent of cycles in which the sender or the receiver holds back.
  int send_idle = 36;
  int recv_idle = 78;
  int cycle_count = 0;

  automation_capture_deadband u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .position(position),
    .level(level),
    .touch_mark(touch_mark),
    .capture_mode(capture_mode),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .point_position(point_position),
    .point_level(point_level),
    .step_shape(step_shape),
    .last_of_run(last_of_run)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("automation_capture_deadband test failed");
      $finish;
    end
  end

  // Receiver side. Outputs are sampled at the edge, before the block's own
  // updates land, so a point counts exactly when valid and ready were both
  // high going into this edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.check_point(point_position, point_level, step_shape, last_of_run);
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  function automatic logic [PW-1:0] rand_position();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[PW-1:0];
  endfunction

  // Offers one word and returns at the edge that accepts it. Valid stays
  // high on return so that back-to-back words follow with no gap; idle
  // gaps before the next word drop it again.
  task automatic send_word(input logic [1:0] k, input logic [PW-1:0] p, input logic [LW-1:0] l,
                           input logic t, input logic [1:0] m);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    position <= p;
    level <= l;
    touch_mark <= t;
    capture_mode <= m;
    do @(posedge clk); while (!in_ready);
    board.note_word(k, p, l, t, m);
  endtask

  // One register write; the enable then drops and the task waits again
  // so back-to-back writes never drive the enable twice at the same edge.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, data);
    @(posedge clk);
  endtask

  // Stops the input and waits for every predicted point to come out. Words
  // that make no point may still be in the pipe, so the task keeps waiting
  // after the last point before anything touches the configuration.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One recording pass: a start, a handful of samples that wander around
  // the deadband, and usually a stop. Positions mostly climb, but the first
  // sample may sit before the start and the stop may land behind the last
  // point, so anchors and closing points are both skipped now and then.
  task automatic record_run(output int words);
    logic [1:0] mode;
    logic [PW-1:0] p;
    logic [PW-1:0] stop_p;
    int lv;
    int span;
    int count;
    words = 0;
    mode = 2'($urandom_range(0, 3));
    p = ($urandom_range(0, 3) == 0) ? PW'($urandom_range(0, 50)) : rand_position();
    lv = $urandom_range(0, FULL);
    send_word(KIND_START, p, lv[LW-1:0], 1'($urandom_range(0, 1)), mode);
    words++;
    p = p + $urandom_range(0, 40) - 8;
    count = $urandom_range(1, 12);
    span = int'(board.tolerance) * 2 + 4;
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) begin
        lv = $urandom_range(0, FULL);
      end else begin
        lv = lv + int'($urandom_range(0, 2 * span)) - span;
        if (lv < 0) lv = 0;
        if (lv > FULL) lv = FULL;
      end
      send_word(KIND_SAMPLE, p, lv[LW-1:0], $urandom_range(0, 4) == 0,
                2'($urandom_range(0, 3)));
      words++;
      p = p + $urandom_range(1, 600);
    end
    // Now and then the stop is left out and the next start drops the run.
    if ($urandom_range(0, 12) != 0) begin
      stop_p = ($urandom_range(0, 3) == 0) ? p - $urandom_range(0, 2000) : p;
      send_word(KIND_STOP, stop_p, LW'($urandom), 1'($urandom), 2'($urandom));
      words++;
    end
  endtask

  initial begin
    int done;
    int n;
    logic [TOL_BITS-1:0] tol;
    board = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A modest deadband so that held points show up.
    write_reg(REG_THIN_TOLERANCE, 16'h0100);
    // Samples, stops and unused kinds while nothing is armed are dropped.
    send_word(KIND_SAMPLE, 5, 16'h1234, 1'b1, MODE_TOUCH);
    send_word(KIND_STOP, 6, '0, 1'b0, MODE_WRITE);
    send_word(KIND_UNUSED, '1, '1, 1'b1, MODE_TRIM);
    // Write run: anchor plus first point, a held point released by a touch
    // sample, then a stop at position zero that only flushes the held point.
    send_word(KIND_START, 100, 16'h8000, 1'b0, MODE_WRITE);
    send_word(KIND_SAMPLE, 200, '1, 1'b0, MODE_WRITE);
    send_word(KIND_SAMPLE, 210, 16'hFFF0, 1'b0, MODE_WRITE);
    send_word(KIND_SAMPLE, 220, '0, 1'b1, MODE_WRITE);
    send_word(KIND_SAMPLE, '1, 16'h0005, 1'b0, MODE_WRITE);
    send_word(KIND_STOP, '0, '0, 1'b0, MODE_WRITE);
    // Touch run: the closing point carries the level from the touch sample.
    send_word(KIND_START, 500, 16'h4000, 1'b1, MODE_TOUCH);
    send_word(KIND_SAMPLE, 400, 16'h4010, 1'b0, MODE_WRITE);
    send_word(KIND_SAMPLE, 410, 16'h2000, 1'b1, MODE_WRITE);
    send_word(KIND_SAMPLE, 415, 16'h2050, 1'b0, MODE_WRITE);
    send_word(KIND_STOP, 420, '1, 1'b1, MODE_TRIM);
    // Latch run stopped before any point: no output at all.
    send_word(KIND_START, 1000, 16'h1111, 1'b0, MODE_LATCH);
    send_word(KIND_STOP, 1001, 16'h1111, 1'b0, MODE_LATCH);
    // Write run whose start lies past the sample, so no anchor and the
    // sample comes out on its own; a trim start then drops the run.
    send_word(KIND_START, '1, '0, 1'b0, MODE_WRITE);
    send_word(KIND_SAMPLE, 10, 16'h0050, 1'b0, MODE_WRITE);
    send_word(KIND_START, 20, 16'h7FFF, 1'b0, MODE_TRIM);
    send_word(KIND_SAMPLE, 5, '1, 1'b0, MODE_WRITE);
    send_word(KIND_STOP, 30, '0, 1'b0, MODE_WRITE);
    // Sample at the start position itself: no anchor, and a stop at the
    // same spot adds no closing point.
    send_word(KIND_START, 7, 16'h0100, 1'b0, MODE_WRITE);
    send_word(KIND_SAMPLE, 7, 16'h0200, 1'b0, MODE_WRITE);
    send_word(KIND_STOP, 7, 16'h0300, 1'b0, MODE_WRITE);
    // The drain doubles as the pause in which the sender waits for every
    // outstanding point before going on.
    drain();

    // Random phases. Each pair of phases shares an idling pattern: first a
    // slow receiver, then a slow sender, then full speed both ways.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          send_idle = 36;
          recv_idle = 78;
        end
        1: begin
          send_idle = 78;
          recv_idle = 36;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      case (ph)
        0: tol = 16'h0000;
        1: tol = 16'h0200;
        2: tol = 16'hFFFF;
        3: tol = TOL_BITS'($urandom_range(1, 16'h0800));
        4: tol = 16'h0100;
        default: tol = 16'h0010;
      endcase
      write_reg(REG_THIN_TOLERANCE, tol);
      write_reg(REG_BOOL_MODE, (ph == 0 || ph == 4) ? 16'd1 : 16'd0);
      done = 0;
      while (done < WORDS_PER_PHASE) begin
        if ($urandom_range(0, 9) == 0) begin
          // Stray word with every field random, kind three included.
          send_word(2'($urandom), rand_position(), LW'($urandom), 1'($urandom),
                    2'($urandom));
        end else begin
          record_run(n);
          done += n;
        end
      end
      drain();
    end

    if (board.errors == 0 && board.pending() == 0) begin
      $display("automation_capture_deadband test passed");
    end else begin
      $display("automation_capture_deadband test failed");
    end
    $finish;
  end

endmodule
